// ===== sv/aokt_pkg.sv =====
package aokt_pkg;

	localparam int CAPACITY     = 64;
	localparam int PAYLOAD_BITS = 64;
	localparam int CNT_W        = $clog2(CAPACITY + 1);
	localparam int KEY_W        = 32;
	localparam int TIME_W       = 32;

	localparam logic [1:0] CMD_UPDATE = 2'd0;
	localparam logic [1:0] CMD_SWEEP  = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_ACT,
		ST_SETTLE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic                    valid;
		logic [KEY_W-1:0]        key;
		logic [PAYLOAD_BITS-1:0] data;
		logic [TIME_W-1:0]       last_seen;
	} entry_t;

	// Broadcast from the sequencer to every cell
	typedef struct packed {
		logic                    match_en;
		logic                    upd_en;
		logic                    sweep_en;
		logic                    compact_en;
		logic [KEY_W-1:0]        key;
		logic [PAYLOAD_BITS-1:0] data;
		logic [TIME_W-1:0]       now;
		logic [TIME_W-1:0]       max_absence;
	} cell_ctrl_t;

endpackage

// ===== sv/aokt_cell.sv =====
module aokt_cell
	import aokt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       ins_sel,
	input  logic       prev_valid,
	input  entry_t     next_ent,
	output entry_t     ent,
	output logic       match,
	output logic       move
);

	logic              valid_q;
	logic [KEY_W-1:0]  key_q;
	logic [PAYLOAD_BITS-1:0] data_q;
	logic [TIME_W-1:0] last_q;
	logic              match_q;
	logic              stale_q;
	logic              take;
	logic [TIME_W-1:0] age;

	// Close holes: a valid cell above an empty one drops into it
	assign move = ctrl.compact_en & valid_q & ~prev_valid;
	assign take = ctrl.compact_en & ~valid_q & next_ent.valid;
	assign age  = ctrl.now - last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
			stale_q <= 1'b0;
		end else begin
			if (ctrl.match_en) begin
				match_q <= valid_q & (key_q == ctrl.key);
				stale_q <= valid_q & (age > ctrl.max_absence);
			end
			if (ctrl.sweep_en && stale_q) begin
				valid_q <= 1'b0;
			end else if (ins_sel || take) begin
				valid_q <= 1'b1;
			end else if (move) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins_sel) begin
			key_q  <= ctrl.key;
			data_q <= ctrl.data;
			last_q <= ctrl.now;
		end else if (ctrl.upd_en && match_q) begin
			data_q <= ctrl.data;
			last_q <= ctrl.now;
		end else if (take) begin
			key_q  <= next_ent.key;
			data_q <= next_ent.data;
			last_q <= next_ent.last_seen;
		end
	end

	assign ent.valid     = valid_q;
	assign ent.key       = key_q;
	assign ent.data      = data_q;
	assign ent.last_seen = last_q;
	assign match         = match_q;

endmodule

// ===== sv/aging_keyed_object_table.sv =====
// Keyed object table with aging, built as a row of entry cells.
// Input channel: in_valid / in_stall with cmd, object_id, object_payload and
// now_ms; a transaction is taken when in_valid is high and in_stall is low.
// cmd update refreshes or inserts an id, sweep evicts entries whose wrapping
// age exceeds max_absence_ms, lookup returns hit and payload.
// Output channel: out_valid / out_stall, one result transaction per input.
// Configuration: cfg_valid / cfg_ready writes max_absence_ms; cfg_ready is
// always high. Write it only while the table is idle.
// Sequence: update, lookup and unused codes step through match, act and
// result, then raise out_valid as the result moves into the output register;
// the next item can be taken once the machine is back in idle. A sweep adds a
// settle state while evicted entries are squeezed out of the row, one cell
// step per cycle, so after each item the free entry is at index occupancy.
// A new item is taken only once the previous result has moved into the
// output register; a waiting result sits there until the receiver takes it.
// Stall: while out_stall holds a result, the next result waits in the
// result stage and in_stall stays high.
// Reset: every entry is empty, max_absence_ms is 1000, no result is pending.
module aging_keyed_object_table
	import aokt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              cmd,
	input  logic [31:0]             object_id,
	input  logic [63:0]             object_payload,
	input  logic [31:0]             now_ms,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    hit,
	output logic                    inserted,
	output logic                    dropped_full,
	output logic [63:0]             payload_out,
	output logic [6:0]              evicted_count,
	output logic [6:0]              occupancy,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [31:0]             cfg_data
);

	state_t                  state_q, state_d;
	cell_ctrl_t              ctrl;
	logic                    ins_en;
	logic [CAPACITY-1:0]     ins_sel;
	logic [CAPACITY-1:0]     match_vec;
	logic [CAPACITY-1:0]     move_vec;
	logic [CAPACITY:0]       valid_vec;
	entry_t                  ent [CAPACITY];
	entry_t                  nxt [CAPACITY];

	// Latched input transaction
	logic [1:0]              cmd_q;
	logic [KEY_W-1:0]        id_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [TIME_W-1:0]       now_q;
	logic [TIME_W-1:0]       max_q;

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_dec;
	logic                    any_hit;
	logic [PAYLOAD_BITS-1:0] hit_data;
	logic                    any_move;
	logic                    room;

	// Result stage and output register
	logic                    res_hit_q, res_ins_q, res_drop_q;
	logic [PAYLOAD_BITS-1:0] res_pay_q;
	logic [CNT_W-1:0]        res_evict_q;
	logic                    out_valid_q;
	logic                    out_hit_q, out_ins_q, out_drop_q;
	logic [PAYLOAD_BITS-1:0] out_pay_q;
	logic [6:0]              out_evict_q, out_occ_q;
	logic                    out_load;

	assign cfg_ready = 1'b1;
	assign room      = count_q < CNT_W'(CAPACITY);

	// Row of cells; cell 0 never moves, the last cell sees an empty neighbour
	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			if (g == CAPACITY - 1) begin : g_last
				assign nxt[g] = '0;
			end else begin : g_mid
				assign nxt[g] = ent[g+1];
			end
			assign ins_sel[g]   = ins_en && (count_q == CNT_W'(g));
			assign valid_vec[g] = ent[g].valid;
			aokt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.ins_sel    (ins_sel[g]),
				.prev_valid ((g == 0) ? 1'b1 : valid_vec[(g == 0) ? 0 : g-1]),
				.next_ent   (nxt[g]),
				.ent        (ent[g]),
				.match      (match_vec[g]),
				.move       (move_vec[g])
			);
		end
	endgenerate
	assign valid_vec[CAPACITY] = 1'b0;

	// Keys are unique, so at most one cell matches: OR its payload out
	always_comb begin
		hit_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match_vec[i]) begin
				hit_data = hit_data | ent[i].data;
			end
		end
	end
	assign any_hit  = |match_vec;
	assign any_move = |move_vec;

	// Once the row is packed, the top of the valid run gives the occupancy
	always_comb begin
		count_dec = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (valid_vec[i] && !valid_vec[i+1]) begin
				count_dec = count_dec | CNT_W'(i + 1);
			end
		end
	end

	assign out_load = (state_q == ST_RESULT) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d          = state_q;
		in_stall         = 1'b1;
		ins_en           = 1'b0;
		ctrl.match_en    = 1'b0;
		ctrl.upd_en      = 1'b0;
		ctrl.sweep_en    = 1'b0;
		ctrl.compact_en  = 1'b0;
		ctrl.key         = id_q;
		ctrl.data        = pay_q;
		ctrl.now         = now_q;
		ctrl.max_absence = max_q;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				ctrl.match_en = 1'b1;
				state_d       = ST_ACT;
			end
			ST_ACT: begin
				if (cmd_q == CMD_UPDATE) begin
					ctrl.upd_en = any_hit;
					ins_en      = !any_hit && room;
				end
				if (cmd_q == CMD_SWEEP) begin
					ctrl.sweep_en = 1'b1;
					state_d       = ST_SETTLE;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_SETTLE: begin
				ctrl.compact_en = 1'b1;
				if (!any_move) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_q   <= 32'd1000;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				max_q <= cfg_data;
			end
			if (ins_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (state_q == ST_SETTLE && !any_move) begin
				count_q <= count_dec;
			end
		end
	end

	// Hold the accepted transaction for the whole item
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q <= cmd;
			id_q  <= object_id;
			pay_q <= object_payload[PAYLOAD_BITS-1:0];
			now_q <= now_ms;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ACT) begin
			res_hit_q   <= any_hit && (cmd_q == CMD_UPDATE || cmd_q == CMD_LOOKUP);
			res_ins_q   <= (cmd_q == CMD_UPDATE) && !any_hit && room;
			res_drop_q  <= (cmd_q == CMD_UPDATE) && !any_hit && !room;
			res_pay_q   <= (cmd_q == CMD_LOOKUP && any_hit) ? hit_data : '0;
			res_evict_q <= '0;
		end
		if (state_q == ST_SETTLE && !any_move) begin
			res_evict_q <= count_q - count_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_hit_q   <= res_hit_q;
			out_ins_q   <= res_ins_q;
			out_drop_q  <= res_drop_q;
			out_pay_q   <= res_pay_q;
			out_evict_q <= 7'(res_evict_q);
			out_occ_q   <= 7'(count_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = out_hit_q;
	assign inserted      = out_ins_q;
	assign dropped_full  = out_drop_q;
	assign payload_out   = 64'(out_pay_q);
	assign evicted_count = out_evict_q;
	assign occupancy     = out_occ_q;

endmodule
